>>> sv/br90_pkg.sv
// Shared constants, types and helpers for the 90-degree bitmap rotator.
package br90_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 1024;
  localparam int SSTRIDE_MAX  = (MAX_WIDTH + 7) / 8;
  localparam int DSTRIDE_MAX  = (MAX_HEIGHT + 7) / 8;
  localparam int STORE_DEPTH  = MAX_HEIGHT * SSTRIDE_MAX;

  localparam int SIZE_W   = 11;                     // size register width
  localparam int SROW_W   = $clog2(MAX_HEIGHT);     // source row index
  localparam int SCOL_W   = $clog2(SSTRIDE_MAX);    // source byte column
  localparam int DROW_W   = $clog2(MAX_WIDTH);      // destination row index
  localparam int DCOL_W   = $clog2(DSTRIDE_MAX);    // destination byte column
  localparam int STRIDE_W = SCOL_W + 1;
  localparam int DSTR_W   = DCOL_W + 1;
  localparam int ADDR_W   = $clog2(STORE_DEPTH);
  localparam int PROD_W   = SROW_W + STRIDE_W;
  localparam int CFG_IDX_W = 1;

  localparam logic [2:0] BIT_MSB = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 1'b1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ISSUE,
    ST_WAIT1,
    ST_WAIT2,
    ST_FINISH
  } state_t;

  // One access to the page store, issued by the sequencer.
  typedef struct packed {
    logic              we;
    logic              rd;
    logic              in_range;
    logic [2:0]        bit_sel;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } store_cmd_t;

  // Zero means one, anything above the maximum means the maximum.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Bytes per row for a size in pixels.
  function automatic logic [STRIDE_W-1:0] stride_of(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] s;
    s = SIZE_W'(v + SIZE_W'(7)) >> 3;
    return STRIDE_W'(s);
  endfunction

endpackage

>>> sv/br90_store.sv
// Page store with registered read and the bit-gather shift register.
module br90_store (
  input  logic                   clk,
  input  logic                   rst,
  input  br90_pkg::store_cmd_t   cmd,
  output logic [7:0]             result
);

  logic [7:0] mem [br90_pkg::STORE_DEPTH];
  logic [7:0] rdata;
  logic       rd_q;
  logic       range_q;
  logic [2:0] sel_q;
  logic       pix;

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.addr] <= cmd.wdata;
    end
    rdata <= mem[cmd.addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_q <= 1'b0;
    end else begin
      rd_q <= cmd.rd;
    end
    range_q <= cmd.in_range;
    sel_q   <= cmd.bit_sel;
  end

  // pixels past the destination row end are pad, forced to zero
  assign pix = range_q & rdata[3'(br90_pkg::BIT_MSB - sel_q)];

  always_ff @(posedge clk) begin
    if (rd_q) begin
      result <= {result[6:0], pix};
    end
  end

endmodule

>>> sv/br90_ctrl.sv
// Sequencer: size registers, page positions and the shared address unit.
module br90_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [br90_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [br90_pkg::SIZE_W-1:0]         cfg_data,
  input  logic                                in_valid,
  input  logic                                in_op,
  input  logic [7:0]                          in_byte,
  output logic                                in_ready,
  input  logic                                out_free,
  output logic                                push,
  output logic                                push_last,
  output br90_pkg::store_cmd_t                cmd
);

  localparam logic [br90_pkg::SIZE_W-1:0] MAXW = br90_pkg::SIZE_W'(br90_pkg::MAX_WIDTH);
  localparam logic [br90_pkg::SIZE_W-1:0] MAXH = br90_pkg::SIZE_W'(br90_pkg::MAX_HEIGHT);

  br90_pkg::state_t state, state_next;

  logic [br90_pkg::SIZE_W-1:0]   width_reg, height_reg;
  logic [br90_pkg::SIZE_W-1:0]   w, h;
  logic [br90_pkg::STRIDE_W-1:0] sstride;
  logic [br90_pkg::DSTR_W-1:0]   dstride;
  logic [2:0]                    cnt;
  logic [7:0]                    data_q;

  logic [br90_pkg::SROW_W-1:0]   load_row;
  logic [br90_pkg::SCOL_W-1:0]   load_col;
  logic [br90_pkg::DROW_W-1:0]   read_row;
  logic [br90_pkg::DCOL_W-1:0]   read_col;

  logic [br90_pkg::DCOL_W+2:0]   dx;
  logic                          dx_ok;
  logic [br90_pkg::SROW_W-1:0]   y_read;
  logic [br90_pkg::SROW_W-1:0]   mul_y;
  logic [br90_pkg::SCOL_W-1:0]   mul_col;
  logic [br90_pkg::PROD_W-1:0]   prod;
  br90_pkg::store_cmd_t          cmd_next;

  assign w       = br90_pkg::clamp_size(width_reg, MAXW);
  assign h       = br90_pkg::clamp_size(height_reg, MAXH);
  assign sstride = br90_pkg::stride_of(w);
  assign dstride = br90_pkg::DSTR_W'(br90_pkg::stride_of(h));

  // destination pixel dx of this row comes from source row h-1-dx
  assign dx     = {read_col, cnt};
  assign dx_ok  = br90_pkg::SIZE_W'(dx) < h;
  assign y_read = br90_pkg::SROW_W'(h - br90_pkg::SIZE_W'(1) - br90_pkg::SIZE_W'(dx));

  // shared address unit: row * stride + byte column
  always_comb begin
    if (state == br90_pkg::ST_LOAD) begin
      mul_y   = load_row;
      mul_col = load_col;
    end else begin
      mul_y   = y_read;
      mul_col = br90_pkg::SCOL_W'(read_row[br90_pkg::DROW_W-1:3]);
    end
    prod = br90_pkg::PROD_W'(mul_y) * br90_pkg::PROD_W'(sstride);
  end

  always_comb begin
    state_next = state;
    case (state)
      br90_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (in_op == br90_pkg::OP_LOAD) ? br90_pkg::ST_LOAD : br90_pkg::ST_ISSUE;
        end
      end
      br90_pkg::ST_LOAD:  state_next = br90_pkg::ST_IDLE;
      br90_pkg::ST_ISSUE: begin
        if (cnt == br90_pkg::BIT_MSB) begin
          state_next = br90_pkg::ST_WAIT1;
        end
      end
      br90_pkg::ST_WAIT1: state_next = br90_pkg::ST_WAIT2;
      br90_pkg::ST_WAIT2: state_next = br90_pkg::ST_FINISH;
      br90_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = br90_pkg::ST_IDLE;
        end
      end
      default: state_next = br90_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready          = (state == br90_pkg::ST_IDLE);
    push              = (state == br90_pkg::ST_FINISH) && out_free;
    push_last         = ({1'b0, read_row} == br90_pkg::SIZE_W'(w - br90_pkg::SIZE_W'(1))) &&
                        ({1'b0, read_col} == br90_pkg::DSTR_W'(dstride - br90_pkg::DSTR_W'(1)));
    cmd_next.we       = (state == br90_pkg::ST_LOAD);
    cmd_next.rd       = (state == br90_pkg::ST_ISSUE);
    cmd_next.in_range = dx_ok;
    cmd_next.bit_sel  = read_row[2:0];
    cmd_next.addr     = br90_pkg::ADDR_W'(prod + br90_pkg::PROD_W'(mul_col));
    cmd_next.wdata    = data_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= br90_pkg::ST_IDLE;
      cnt        <= '0;
      cmd        <= '0;
      width_reg  <= MAXW;
      height_reg <= MAXH;
      load_row   <= '0;
      load_col   <= '0;
      read_row   <= '0;
      read_col   <= '0;
    end else begin
      state <= state_next;
      cmd   <= cmd_next;
      cnt   <= (state == br90_pkg::ST_ISSUE) ? 3'(cnt + 3'd1) : 3'd0;
      if (cfg_we) begin
        if (cfg_index == br90_pkg::REG_SOURCE_WIDTH) begin
          width_reg <= cfg_data;
        end else begin
          height_reg <= cfg_data;
        end
        load_row <= '0;
        load_col <= '0;
        read_row <= '0;
        read_col <= '0;
      end else begin
        if (state == br90_pkg::ST_LOAD) begin
          if (br90_pkg::STRIDE_W'({1'b0, load_col} + 1'b1) >= sstride) begin
            load_col <= '0;
            if (br90_pkg::SIZE_W'({1'b0, load_row} + 1'b1) >= h) begin
              load_row <= '0;
            end else begin
              load_row <= br90_pkg::SROW_W'(load_row + 1'b1);
            end
          end else begin
            load_col <= br90_pkg::SCOL_W'(load_col + 1'b1);
          end
        end
        if (push) begin
          if (br90_pkg::DSTR_W'({1'b0, read_col} + 1'b1) >= dstride) begin
            read_col <= '0;
            if (br90_pkg::SIZE_W'({1'b0, read_row} + 1'b1) >= w) begin
              read_row <= '0;
            end else begin
              read_row <= br90_pkg::DROW_W'(read_row + 1'b1);
            end
          end else begin
            read_col <= br90_pkg::DCOL_W'(read_col + 1'b1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_q <= in_byte;
    end
  end

endmodule

>>> sv/bitmap_rotate_90.sv
// Top level of the 90-degree rotator for packed 1-bit-per-pixel pages.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tuser=op, tdata=source_byte
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata=rotated_byte, tlast=last_of_page
//  cfg       in   cfg_we (no wait)               cfg_index, cfg_data
//
// A load item passes through the accept step and the LOAD step, which uses the shared
// row*stride+column unit; the store write lands from the registered command,
// overlapping the next accept.
// A read item passes from its accept through eight address issues (one source
// row per destination pixel), two wait steps for the registered store read and
// the bit gather, and a finish step that moves the byte to the output
// register, from which it shows on m_axis; no new item is taken before then.
// Reset (rst, synchronous) sets both sizes to 1024 and all positions to
// zero; the store keeps its contents and is undefined until loaded.
// A full output register stalls the sequencer in its last step; a load can
// still be taken while a finished byte waits on m_axis.
module bitmap_rotate_90 (
  input  logic                               clk,
  input  logic                               rst,
  // configuration writes
  input  logic                               cfg_we,
  input  logic [br90_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [br90_pkg::SIZE_W-1:0]        cfg_data,
  // input items
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,  // [7:0] source_byte
  input  logic                               s_axis_tuser,  // [0] op
  // result items
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [7:0]                         m_axis_tdata,  // [7:0] rotated_byte
  output logic                               m_axis_tlast
);

  br90_pkg::store_cmd_t cmd;
  logic [7:0]           result;
  logic                 push;
  logic                 push_last;
  logic                 out_free;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  br90_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_axis_tvalid),
    .in_op     (s_axis_tuser),
    .in_byte   (s_axis_tdata),
    .in_ready  (s_axis_tready),
    .out_free  (out_free),
    .push      (push),
    .push_last (push_last),
    .cmd       (cmd)
  );

  br90_store u_store (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .result (result)
  );

  // output register: holds a finished byte until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (push) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      m_axis_tdata <= result;
      m_axis_tlast <= push_last;
    end
  end

endmodule

>>> sv/br90_check.sv
// Port-level checks for the rotator, bound to the top level.
module br90_check (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [7:0]                     m_axis_tdata,
  input logic                           m_axis_tlast
);

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result payload changed while stalled");

  // a load never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    s_acc && s_axis_tuser == br90_pkg::OP_LOAD && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared after a load");

  // a read holds off further input while it is in progress
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    s_acc && s_axis_tuser == br90_pkg::OP_READ |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input taken while a read is in progress");

endmodule

bind bitmap_rotate_90 br90_check u_br90_check (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
